### rtl/core/pe2c_pkg.sv
// ----------------------------------------------------------------------------
// pe2c_pkg
// Shared widths, codes and types of the two-choice least-cost host selector.
// ----------------------------------------------------------------------------
package pe2c_pkg;

	localparam int RND_W        = 64;
	localparam int RTT_W        = 32;
	localparam int ACT_W        = 16;
	localparam int PEN_W        = 48;
	localparam int HC_W         = 9;
	localparam int HIDX_W       = 8;
	localparam int COST_W       = 49;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 48;
	localparam int REM_DIG      = 2;   // quotient bits retired per cycle
	localparam int SECOND_SHIFT = 16;
	localparam int ACT_FRAC_W   = 16;  // Q16.16 scaling of the active count

	localparam logic [HC_W-1:0]  HOST_COUNT_RST   = '0;
	localparam logic [RTT_W-1:0] DEFAULT_RTT_RST  = 32'd655360;
	localparam logic [PEN_W-1:0] PENALTY_COST_RST = 48'd65536000000;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOST_COUNT   = 2'd0,
		REG_DEFAULT_RTT  = 2'd1,
		REG_PENALTY_COST = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [RTT_W-1:0] rtt;
		logic [ACT_W-1:0] act;
	} host_entry_t;

	typedef struct packed {
		logic [RTT_W-1:0] default_rtt;
		logic [PEN_W-1:0] penalty_cost;
	} cost_cfg_t;

endpackage

### rtl/core/peak_ewma_two_choice_select_top.sv
// ----------------------------------------------------------------------------
// peak_ewma_two_choice_select_top
// Two-choice least-cost host selector over a per-host RTT/active table.
// ----------------------------------------------------------------------------
// Write transaction: no result; the next item is taken the cycle after.
// Select with two or more hosts: two passes of the shared radix-4 remainder
// unit pick two hosts, both are read and costed, and no new item is taken
// until the result goes to the output register. Zero or one host: no passes.
// Reset: registers back to defaults, then a sweep zeroes the host table;
// in_stall stays high during the sweep, config writes are taken.
module peak_ewma_two_choice_select_top #(
	parameter int MAX_HOSTS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pe2c_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pe2c_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [pe2c_pkg::HIDX_W-1:0]      host_index,
	input  logic [pe2c_pkg::RTT_W-1:0]       rtt_value,
	input  logic [pe2c_pkg::ACT_W-1:0]       active_count,
	input  logic [pe2c_pkg::RND_W-1:0]       rand_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [pe2c_pkg::HIDX_W-1:0]      chosen_host,
	output logic                             no_host
);
	import pe2c_pkg::*;

	localparam int AW = $clog2(MAX_HOSTS);
	localparam int NW = $clog2(MAX_HOSTS + 1);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_MOD1  = 9'b000000100,
		S_MOD2  = 9'b000001000,
		S_RD1   = 9'b000010000,
		S_CST1  = 9'b000100000,
		S_CST2  = 9'b001000000,
		S_CMP   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [HC_W-1:0]   host_count_q;
	cost_cfg_t         cfg_q;
	logic [RND_W-1:0]  rnd_q;
	logic [AW-1:0]     first_q;
	logic [AW-1:0]     second_q;
	logic [COST_W-1:0] c1_q;
	logic [HIDX_W-1:0] res_host_q;
	logic              res_none_q;
	logic              out_valid_q;
	logic [HIDX_W-1:0] chosen_q;
	logic              none_q;

	logic              in_acc;
	logic              sel_acc;
	logic [NW-1:0]     n;
	logic              n_small;
	logic              rem_start;
	logic [RND_W-1:0]  rem_dvd;
	logic [NW-1:0]     rem_dsr;
	logic [NW-1:0]     rem;
	logic              rem_done;
	logic [NW:0]       sum2;
	logic [AW-1:0]     second_nx;
	logic              mem_wr_en;
	logic [AW-1:0]     rd_addr;
	host_entry_t       wr_entry;
	host_entry_t       rd_entry;
	logic              mem_ready;
	logic              cost_en;
	logic [COST_W-1:0] cost;
	logic              pick_first;
	logic              out_load;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_count_q       <= HOST_COUNT_RST;
			cfg_q.default_rtt  <= DEFAULT_RTT_RST;
			cfg_q.penalty_cost <= PENALTY_COST_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HOST_COUNT:   host_count_q       <= cfg_data[HC_W-1:0];
				REG_DEFAULT_RTT:  cfg_q.default_rtt  <= cfg_data[RTT_W-1:0];
				REG_PENALTY_COST: cfg_q.penalty_cost <= cfg_data[PEN_W-1:0];
				default: ;
			endcase
		end
	end

	// effective host count, saturated to the table depth
	always_comb begin
		n       = (32'(host_count_q) > MAX_HOSTS) ? NW'(MAX_HOSTS) : NW'(host_count_q);
		n_small = (n < NW'(2));
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign sel_acc  = in_acc && (op == OP_SELECT);

	// ---------------- host table ----------------
	assign mem_wr_en = in_acc && (op == OP_WRITE) && (32'(host_index) < MAX_HOSTS);
	assign wr_entry  = '{rtt: rtt_value, act: active_count};
	assign rd_addr   = (state_q == S_RD1) ? first_q : second_q;

	pe2c_host_mem #(
		.MAX_HOSTS(MAX_HOSTS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (mem_wr_en),
		.wr_addr  (AW'(host_index)),
		.wr_entry (wr_entry),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.ready    (mem_ready)
	);

	// ---------------- remainder unit ----------------
	always_comb begin
		if (state_q == S_IDLE) begin
			rem_start = sel_acc && !n_small;
			rem_dvd   = rand_word;
			rem_dsr   = n;
		end else begin
			rem_start = (state_q == S_MOD1) && rem_done;
			rem_dvd   = rnd_q >> SECOND_SHIFT;
			rem_dsr   = n - 1'b1;
		end
	end

	pe2c_rem_unit #(
		.DIV_W(NW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dvd),
		.divisor  (rem_dsr),
		.rem      (rem),
		.done     (rem_done)
	);

	// second = (first + 1 + r2) mod n, sum stays below 2n
	always_comb begin
		sum2 = (NW + 1)'(first_q) + (NW + 1)'(rem) + 1'b1;
		if (sum2 >= {1'b0, n}) begin
			sum2 = sum2 - {1'b0, n};
		end
		second_nx = AW'(sum2);
	end

	// ---------------- cost unit ----------------
	assign cost_en = (state_q == S_CST1) || (state_q == S_CST2);

	pe2c_cost_unit u_cost (
		.clk   (clk),
		.en    (cost_en),
		.entry (rd_entry),
		.cfg   (cfg_q),
		.cost  (cost)
	);

	assign pick_first = (c1_q == cost) ? rnd_q[0] : (c1_q < cost);

	// ---------------- sequencer ----------------
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (mem_ready) state_q <= S_IDLE;
				S_IDLE: begin
					if (sel_acc) begin
						state_q <= n_small ? S_OUT : S_MOD1;
					end
				end
				S_MOD1:  if (rem_done) state_q <= S_MOD2;
				S_MOD2:  if (rem_done) state_q <= S_RD1;
				S_RD1:   state_q <= S_CST1;
				S_CST1:  state_q <= S_CST2;
				S_CST2:  state_q <= S_CMP;
				S_CMP:   state_q <= S_OUT;
				S_OUT:   if (out_load) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sel_acc) begin
			rnd_q      <= rand_word;
			res_host_q <= '0;
			res_none_q <= (n == '0);
		end
		if ((state_q == S_MOD1) && rem_done) begin
			first_q <= AW'(rem);
		end
		if ((state_q == S_MOD2) && rem_done) begin
			second_q <= second_nx;
		end
		if (state_q == S_CST2) begin
			c1_q <= cost;
		end
		if (state_q == S_CMP) begin
			res_host_q <= HIDX_W'(pick_first ? first_q : second_q);
			res_none_q <= 1'b0;
		end
		if (out_load) begin
			chosen_q <= res_host_q;
			none_q   <= res_none_q;
		end
	end

	// output register decouples the result from the next transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_host = chosen_q;
	assign no_host     = none_q;

endmodule

### rtl/core/pe2c_rem_unit.sv
// ----------------------------------------------------------------------------
// pe2c_rem_unit
// Iterative restoring remainder of a 64-bit word by a narrow divisor.
// ----------------------------------------------------------------------------
module pe2c_rem_unit #(
	parameter int DIV_W = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pe2c_pkg::RND_W-1:0] dividend,
	input  logic [DIV_W-1:0]          divisor,
	output logic [DIV_W-1:0]          rem,
	output logic                      done
);
	import pe2c_pkg::*;

	localparam int STEPS = RND_W / REM_DIG;
	localparam int CW    = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [RND_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  rem_nx;

	// two shift/compare/subtract steps per cycle
	always_comb begin
		logic [DIV_W:0]   t;
		logic [DIV_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < REM_DIG; i++) begin
			t = {r, dvd_q[RND_W-1-i]};
			if (t >= {1'b0, dsr_q}) begin
				t = t - {1'b0, dsr_q};
			end
			r = t[DIV_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << REM_DIG;
			rem_q <= rem_nx;
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

### rtl/core/pe2c_host_mem.sv
// ----------------------------------------------------------------------------
// pe2c_host_mem
// Per-host RTT / active-count table with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pe2c_host_mem #(
	parameter int MAX_HOSTS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_HOSTS)-1:0] wr_addr,
	input  pe2c_pkg::host_entry_t        wr_entry,
	input  logic [$clog2(MAX_HOSTS)-1:0] rd_addr,
	output pe2c_pkg::host_entry_t        rd_entry,
	output logic                         ready
);
	import pe2c_pkg::*;

	localparam int AW = $clog2(MAX_HOSTS);

	host_entry_t   mem [MAX_HOSTS];
	host_entry_t   rd_q;
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(MAX_HOSTS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_entry = rd_q;
	assign ready    = !clearing_q;

endmodule

### rtl/core/pe2c_cost_unit.sv
// ----------------------------------------------------------------------------
// pe2c_cost_unit
// Registered cost of one host entry: rtt*(active+1) or penalty+active*2^16.
// ----------------------------------------------------------------------------
module pe2c_cost_unit (
	input  logic                        clk,
	input  logic                        en,
	input  pe2c_pkg::host_entry_t       entry,
	input  pe2c_pkg::cost_cfg_t         cfg,
	output logic [pe2c_pkg::COST_W-1:0] cost
);
	import pe2c_pkg::*;

	logic [RTT_W-1:0]  mul_a;
	logic [ACT_W:0]    mul_b;
	logic [COST_W-1:0] prod;
	logic [COST_W-1:0] pen;
	logic              no_sample_busy;
	logic [COST_W-1:0] cost_q;

	always_comb begin
		mul_a          = (entry.rtt != '0) ? entry.rtt : cfg.default_rtt;
		mul_b          = {1'b0, entry.act} + 1'b1;
		prod           = COST_W'(mul_a) * COST_W'(mul_b);
		pen            = COST_W'(cfg.penalty_cost)
		               + COST_W'({entry.act, {ACT_FRAC_W{1'b0}}});
		no_sample_busy = (entry.rtt == '0) && (entry.act != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cost_q <= no_sample_busy ? pen : prod;
		end
	end

	assign cost = cost_q;

endmodule

### rtl/core/pe2c_checker.sv
// ----------------------------------------------------------------------------
// pe2c_checker
// Port-level checks of the host selector, bound to the top level.
// ----------------------------------------------------------------------------
module pe2c_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          op,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pe2c_pkg::HIDX_W-1:0]   chosen_host,
	input logic                          no_host
);
	import pe2c_pkg::*;

	// an empty pool never names a host
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_host |-> chosen_host == '0)
		else $error("no_host result carries a nonzero host");

	// a select occupies the sequencer after acceptance
	a_sel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_SELECT) |=> in_stall)
		else $error("select transaction did not block the input");

	// a table write leaves the input open in the cycle after
	a_wr_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_WRITE) |=> !in_stall)
		else $error("write transaction stalled the input");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(chosen_host) && $stable(no_host))
		else $error("stalled result changed");

endmodule

bind peak_ewma_two_choice_select_top pe2c_checker u_pe2c_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.op          (op),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.chosen_host (chosen_host),
	.no_host     (no_host)
);

### tb/tb_peak_ewma_two_choice_select_top.sv
// ----------------------------------------------------------------------------
// tb_peak_ewma_two_choice_select_top
// Self-checking bench for the two-choice least-cost host selector: table
// writes and select requests go in through the input channel, and each select
// is predicted here from a local copy of the host table and the cost registers.
// Each result is compared in order. Register settings change between phases,
// and the phases vary how often the sender idles and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_peak_ewma_two_choice_select_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pe2c_pkg::*;

	localparam int HOSTS        = 256;
	localparam int HOLD_CYCLES  = 500;
	localparam int SETTLE       = 4;    // slack for the last table write to land in the table
	localparam int DRAIN_SLACK  = 100;  // margin for any select still in flight
	localparam int PHASE_ITEMS  = 163;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // not mapped, must be ignored

	typedef struct {
		logic              op;
		logic [HIDX_W-1:0] hidx;
		logic [RTT_W-1:0]  rtt;
		logic [ACT_W-1:0]  act;
		logic [RND_W-1:0]  rnd;
	} host_req_t;

	typedef struct {
		logic [HIDX_W-1:0] host;
		logic              vacant;
	} pick_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic                  op           = OP_WRITE;
	logic [HIDX_W-1:0]     host_index   = '0;
	logic [RTT_W-1:0]      rtt_value    = '0;
	logic [ACT_W-1:0]      active_count = '0;
	logic [RND_W-1:0]      rand_word    = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [HIDX_W-1:0]     chosen_host;
	logic                  no_host;

	// local copy of the block's state and registers
	logic [RTT_W-1:0] rtt_tab [HOSTS];
	logic [ACT_W-1:0] act_tab [HOSTS];
	logic [HC_W-1:0]  cfg_host_count  = HOST_COUNT_RST;
	logic [RTT_W-1:0] cfg_default_rtt = DEFAULT_RTT_RST;
	logic [PEN_W-1:0] cfg_penalty     = PENALTY_COST_RST;

	host_req_t req_q[$];
	pick_t     pick_q[$];
	host_req_t cur;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int n_errors      = 0;
	int n_writes      = 0;
	int n_selects     = 0;
	int n_results     = 0;
	int n_cfg         = 0;

	peak_ewma_two_choice_select_top #(
		.MAX_HOSTS(HOSTS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.host_index  (host_index),
		.rtt_value   (rtt_value),
		.active_count(active_count),
		.rand_word   (rand_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.chosen_host (chosen_host),
		.no_host     (no_host)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (n_errors < 20)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_errors++;
	endtask

	function automatic void add_req(input host_req_t r);
		req_q.insert(req_q.size(), r);
	endfunction

	function automatic logic [63:0] host_cost(input int idx);
		logic [63:0] r;
		logic [63:0] a;
		r = 64'(rtt_tab[idx]);
		a = 64'(act_tab[idx]);
		if (r == 0 && a != 0)
			return {16'd0, cfg_penalty} + (a << ACT_FRAC_W);
		if (r != 0)
			return r * (a + 64'd1);
		return {32'd0, cfg_default_rtt} * (a + 64'd1);
	endfunction

	function automatic pick_t predict_pick(input logic [RND_W-1:0] rnd);
		pick_t p;
		logic [63:0] n;
		logic [63:0] first;
		logic [63:0] second;
		logic [63:0] c1;
		logic [63:0] c2;
		logic take_first;
		n = (cfg_host_count > HOSTS) ? 64'(HOSTS) : 64'(cfg_host_count);
		p.host = '0;
		p.vacant = (n == 0);
		if (n > 1) begin
			first  = rnd % n;
			second = (first + 64'd1 + (rnd >> SECOND_SHIFT) % (n - 64'd1)) % n;
			c1 = host_cost(int'(first));
			c2 = host_cost(int'(second));
			take_first = (c1 == c2) ? rnd[0] : (c1 < c2);
			p.host = take_first ? first[HIDX_W-1:0] : second[HIDX_W-1:0];
		end
		return p;
	endfunction

	// bookkeeping for one accepted input transaction
	function automatic void account_request(input host_req_t r);
		if (r.op == OP_WRITE) begin
			rtt_tab[r.hidx] = r.rtt;
			act_tab[r.hidx] = r.act;
			n_writes++;
		end else begin
			pick_q.insert(pick_q.size(), predict_pick(r.rnd));
			n_selects++;
		end
	endfunction

	function automatic host_req_t write_req(input logic [HIDX_W-1:0] idx,
			input logic [RTT_W-1:0] rtt, input logic [ACT_W-1:0] act);
		host_req_t r;
		r.op   = OP_WRITE;
		r.hidx = idx;
		r.rtt  = rtt;
		r.act  = act;
		r.rnd  = {$urandom, $urandom};
		return r;
	endfunction

	function automatic host_req_t select_req(input logic [RND_W-1:0] rnd);
		host_req_t r;
		r.op   = OP_SELECT;
		r.hidx = HIDX_W'($urandom);
		r.rtt  = $urandom;
		r.act  = ACT_W'($urandom);
		r.rnd  = rnd;
		return r;
	endfunction

	// small values are favored so that equal costs come up often
	function automatic host_req_t rand_request(input int span);
		host_req_t r;
		logic [RTT_W-1:0] rtt;
		logic [ACT_W-1:0] act;
		logic [HIDX_W-1:0] idx;
		case ($urandom_range(3))
			0: rtt = '0;
			1: rtt = $urandom_range(4);
			2: rtt = $urandom;
			default: rtt = '1;
		endcase
		case ($urandom_range(3))
			0: act = '0;
			1: act = ACT_W'($urandom_range(3));
			2: act = ACT_W'($urandom);
			default: act = '1;
		endcase
		idx = ($urandom_range(3) != 0) ? HIDX_W'($urandom_range(span - 1)) : HIDX_W'($urandom);
		if ($urandom_range(99) < 60)
			r = select_req({$urandom, $urandom});
		else
			r = write_req(idx, rtt, act);
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HOST_COUNT:   cfg_host_count  = data[HC_W-1:0];
			REG_DEFAULT_RTT:  cfg_default_rtt = data[RTT_W-1:0];
			REG_PENALTY_COST: cfg_penalty     = data[PEN_W-1:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// wait until the block is idle: nothing pending, nothing in flight
	task automatic drain();
		@(negedge clk);
		while (req_q.size() != 0 || in_valid || pick_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(input int count, input logic [HC_W-1:0] hc,
			input logic [RTT_W-1:0] drtt, input logic [PEN_W-1:0] pen,
			input int s_idle, input int r_idle, input bit hold_off);
		logic [CFG_DATA_W-1:0] junk;
		int span;
		drain();
		junk = CFG_DATA_W'({$urandom, $urandom});
		write_reg(REG_HOST_COUNT, {junk[CFG_DATA_W-1:HC_W], hc});
		write_reg(REG_DEFAULT_RTT, {junk[CFG_DATA_W-1:RTT_W], drtt});
		write_reg(REG_PENALTY_COST, pen);
		@(negedge clk);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		span = (hc == 0 || hc > HOSTS) ? HOSTS : int'(hc);
		for (int i = 0; i < count; i++)
			add_req(rand_request(span));
		if (hold_off)
			hold_req++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				account_request(cur);
			if (!in_valid || !in_stall) begin
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur = req_q.pop_front();
					in_valid     <= 1'b1;
					op           <= cur.op;
					host_index   <= cur.hidx;
					rtt_value    <= cur.rtt;
					active_count <= cur.act;
					rand_word    <= cur.rnd;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin : result_mon
		pick_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pick_q.size() == 0) begin
				report_mismatch($sformatf("result with none pending: host %0d no_host %0b",
					chosen_host, no_host));
			end else begin
				want = pick_q.pop_front();
				n_results++;
				if (chosen_host !== want.host)
					report_mismatch($sformatf("result %0d: chosen_host %0d, want %0d",
						n_results, chosen_host, want.host));
				if (no_host !== want.vacant)
					report_mismatch($sformatf("result %0d: no_host %0b, want %0b",
						n_results, no_host, want.vacant));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < HOSTS; i++) begin
			rtt_tab[i] = '0;
			act_tab[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, no eligible host
		send_idle_pct = 25;
		recv_idle_pct = 47;
		add_req(select_req('1));
		add_req(select_req('0));
		add_req(write_req(8'd255, '1, '1));
		add_req(write_req(8'd0, '0, '0));

		// single host
		run_phase(0, 9'd1, DEFAULT_RTT_RST, PENALTY_COST_RST, 25, 47, 1'b0);
		add_req(select_req('1));

		// three hosts: penalty, default and an rtt equal to the default
		run_phase(0, 9'd3, DEFAULT_RTT_RST, PENALTY_COST_RST, 25, 47, 1'b0);
		add_req(write_req(8'd0, '0, 16'd5));
		add_req(write_req(8'd1, '0, '0));
		add_req(write_req(8'd2, DEFAULT_RTT_RST, '0));
		add_req(select_req(64'd1));
		add_req(select_req(64'd4));
		add_req(select_req(64'd0));
		add_req(select_req(64'h0000_0000_0001_0000));

		// full table, largest costs
		run_phase(0, 9'd256, '1, '1, 25, 47, 1'b0);
		add_req(write_req(8'd254, '0, '1));
		add_req(select_req('1));
		add_req(select_req(64'h8000_0000_00FE_00FF));

		// count above the table, zero costs; an unmapped register index
		run_phase(0, 9'd511, '0, '0, 25, 47, 1'b0);
		write_reg(REG_SPARE, '1);
		@(negedge clk);
		add_req(write_req(8'd0, '0, 16'd1));
		add_req(select_req('1));
		add_req(select_req({$urandom, $urandom}));

		// random phases: sender 25 / receiver 47, then swapped, then no idling
		run_phase(PHASE_ITEMS, 9'd2, DEFAULT_RTT_RST, PENALTY_COST_RST, 25, 47, 1'b0);
		run_phase(PHASE_ITEMS, 9'd3, 32'd1, '0, 25, 47, 1'b0);
		run_phase(PHASE_ITEMS, 9'd256, $urandom, PEN_W'({$urandom, $urandom}), 25, 47, 1'b0);
		run_phase(PHASE_ITEMS, HC_W'($urandom_range(256, 2)), '0, '1, 25, 47, 1'b0);
		run_phase(PHASE_ITEMS, 9'd17, '1, PEN_W'({$urandom, $urandom}), 47, 25, 1'b0);
		run_phase(PHASE_ITEMS, 9'd1, $urandom, PEN_W'({$urandom, $urandom}), 47, 25, 1'b0);
		run_phase(PHASE_ITEMS, 9'd0, $urandom, PEN_W'({$urandom, $urandom}), 47, 25, 1'b0);
		run_phase(PHASE_ITEMS, 9'd255, 32'd2, 48'd3, 0, 0, 1'b1);
		run_phase(PHASE_ITEMS, 9'd511, $urandom, PEN_W'({$urandom, $urandom}), 0, 0, 1'b0);
		run_phase(PHASE_ITEMS, HC_W'($urandom_range(8, 2)), $urandom_range(4),
			PEN_W'({$urandom, $urandom}), 0, 0, 1'b0);

		drain();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (pick_q.size() != 0)
			report_mismatch($sformatf("%0d selections never answered", pick_q.size()));

		$display("covered %0d transactions (%0d table writes, %0d selects), %0d results",
			n_writes + n_selects, n_writes, n_selects, n_results);
		$display("%0d reg writes, counts zero to past the table, ties, a %0d-cycle hold-off",
			n_cfg, HOLD_CYCLES);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
rtl/core/pe2c_pkg.sv
rtl/core/pe2c_rem_unit.sv
rtl/core/pe2c_host_mem.sv
rtl/core/pe2c_cost_unit.sv
rtl/core/peak_ewma_two_choice_select_top.sv
rtl/core/pe2c_checker.sv
tb/tb_peak_ewma_two_choice_select_top.sv
